[design/dvr_pkg.sv]
// ----------------------------------------------------------------------------
// dvr_pkg
// Shared types and constants of the date validate and reorder block.
// ----------------------------------------------------------------------------
package dvr_pkg;

    // Text length of a complete date yyyy-mm-dd
    localparam logic [3:0] DATE_LEN   = 4'd10;
    // Positions of the two separators in the incoming text
    localparam logic [3:0] SEP_POS_A  = 4'd4;
    localparam logic [3:0] SEP_POS_B  = 4'd7;
    // Number of characters in a valid result
    localparam logic [3:0] OUT_LEN    = 4'd10;

    localparam logic [7:0] ASCII_DASH = 8'h2D;
    localparam logic [7:0] ASCII_ZERO = 8'h30;
    localparam logic [7:0] ASCII_NINE = 8'h39;

    // One classified date: verdict plus the digits y y y y m m d d
    typedef struct packed {
        logic            ok;
        logic [7:0][3:0] digits;
    } dvr_rec_t;

endpackage

[design/dvr_in_if.sv]
// ----------------------------------------------------------------------------
// dvr_in_if
// Character input channel: one text character per item.
// ----------------------------------------------------------------------------
interface dvr_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_char;
    logic       end_of_text;

    modport source (output valid, output in_char, output end_of_text, input ready);
    modport sink   (input valid, input in_char, input end_of_text, output ready);
endinterface

[design/dvr_out_if.sv]
// ----------------------------------------------------------------------------
// dvr_out_if
// Result channel: one output character or one error marker per item.
// ----------------------------------------------------------------------------
interface dvr_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_char;
    logic       date_ok;
    logic       final_char;

    modport source (output valid, output out_char, output date_ok, output final_char,
                    input ready);
    modport sink   (input valid, input out_char, input date_ok, input final_char,
                    output ready);
endinterface

[design/iso_date_validate_reorder_core.sv]
// ----------------------------------------------------------------------------
// iso_date_validate_reorder_core
// Checks a yyyy-mm-dd date text and rewrites it as dd-mm-yyyy.
// ----------------------------------------------------------------------------
// Usage:
//   din carries one text character per item; end_of_text marks the last one.
//   dout carries ten characters of dd-mm-yyyy with date_ok set, final_char on
//   the tenth, or a single item with out_char 0, date_ok 0, final_char 1
//   when the text is malformed or not a real calendar date.
// Timing:
//   The front stage takes one character per cycle while din.ready is high. At
//   the last character the date is classified and pushed into a QUEUE_DEPTH-entry
//   record queue; the record passes from the queue into the output register
//   before the first result is valid. The back stage emits one result item per
//   cycle while dout.ready is high, so the ten output items of a valid date
//   match the ten input characters of the next date.
// Reset:
//   Clears the character position, error flag, queue, output index and output valid flag.
// Stall:
//   The output register holds while dout.ready is low; din.ready drops only
//   once the record queue is full.
// ----------------------------------------------------------------------------
module iso_date_validate_reorder_core #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic      clk,
    input  logic      rst_n,
    dvr_in_if.sink    din,
    dvr_out_if.source dout
);

    dvr_pkg::dvr_rec_t push_rec;
    dvr_pkg::dvr_rec_t head_rec;
    logic              push;
    logic              pop;
    logic              full;
    logic              empty;

    // Parse and classify
    dvr_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .din        (din),
        .queue_full (full),
        .push       (push),
        .push_rec   (push_rec)
    );

    // Decouple the two sides
    dvr_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_rec (push_rec),
        .pop      (pop),
        .full     (full),
        .empty    (empty),
        .head_rec (head_rec)
    );

    // Emit the reordered text
    dvr_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .empty    (empty),
        .head_rec (head_rec),
        .pop      (pop),
        .dout     (dout)
    );

endmodule

[design/dvr_front.sv]
// ----------------------------------------------------------------------------
// dvr_front
// Accepts characters, checks the format, stores the digits and, at the last
// character, classifies the date and pushes one record to the queue.
// ----------------------------------------------------------------------------
module dvr_front (
    input  logic              clk,
    input  logic              rst_n,
    dvr_in_if.sink            din,
    input  logic              queue_full,
    output logic              push,
    output dvr_pkg::dvr_rec_t push_rec
);

    logic [3:0]      pos_reg, pos_next;
    logic            err_reg, err_next;
    logic [7:0][3:0] digits_reg, digits_next;

    logic            accept;
    logic            is_digit;
    logic            is_dash;
    logic            bad_char;
    logic [2:0]      slot;
    logic [3:0]      pos_after;
    logic            err_after;
    logic            date_good;

    // True when the two-digit number tens,ones is a multiple of four
    function automatic logic div_by_4(input logic [3:0] tens, input logic [3:0] ones);
        logic r;
        if (tens[0])
            r = ones inside {4'd2, 4'd6};
        else
            r = ones inside {4'd0, 4'd4, 4'd8};
        return r;
    endfunction

    // Days in a month of a common year
    function automatic logic [4:0] month_len(input logic [6:0] month);
        logic [4:0] d;
        case (month)
            7'd2:                        d = 5'd28;
            7'd4, 7'd6, 7'd9, 7'd11:     d = 5'd30;
            default:                     d = 5'd31;
        endcase
        return d;
    endfunction

    // Calendar check on the stored digits y y y y m m d d
    function automatic logic check_date(input logic [7:0][3:0] d);
        logic [6:0] month;
        logic [6:0] day;
        logic [4:0] max_day;
        logic       century;
        logic       leap;
        logic       r;
        month   = {d[4], 3'b000} + {2'b00, d[4], 1'b0} + {3'b000, d[5]};
        day     = {d[6], 3'b000} + {2'b00, d[6], 1'b0} + {3'b000, d[7]};
        century = (d[2] == 4'd0) && (d[3] == 4'd0);
        leap    = div_by_4(d[2], d[3]) && (!century || div_by_4(d[0], d[1]));
        max_day = month_len(month);
        if ((month == 7'd2) && leap)
            max_day = 5'd29;
        r = ((d[0] | d[1] | d[2] | d[3]) != 4'd0)
            && (month != 7'd0) && (month <= 7'd12)
            && (day != 7'd0) && (day <= {2'b00, max_day});
        return r;
    endfunction

    assign din.ready = !queue_full;
    assign accept    = din.valid && din.ready;

    // Classify the incoming character
    always_comb
    begin
        is_digit = din.in_char inside {[dvr_pkg::ASCII_ZERO : dvr_pkg::ASCII_NINE]};
        is_dash  = (din.in_char == dvr_pkg::ASCII_DASH);
        if (pos_reg >= dvr_pkg::DATE_LEN)
            bad_char = 1'b1;
        else if ((pos_reg == dvr_pkg::SEP_POS_A) || (pos_reg == dvr_pkg::SEP_POS_B))
            bad_char = !is_dash;
        else
            bad_char = !is_digit;

        if (pos_reg < dvr_pkg::SEP_POS_A)
            slot = pos_reg[2:0];
        else if (pos_reg < dvr_pkg::SEP_POS_B)
            slot = 3'(pos_reg - 4'd1);
        else
            slot = 3'(pos_reg - 4'd2);
    end

    // Store the digit, advance the position, collect the verdict
    always_comb
    begin
        digits_next = digits_reg;
        if (!bad_char && (pos_reg != dvr_pkg::SEP_POS_A) && (pos_reg != dvr_pkg::SEP_POS_B))
            digits_next[slot] = 4'(din.in_char - dvr_pkg::ASCII_ZERO);
        pos_after = (pos_reg < dvr_pkg::DATE_LEN) ? pos_reg + 4'd1 : pos_reg;
        err_after = err_reg | bad_char;
        date_good = !err_after && (pos_after == dvr_pkg::DATE_LEN) && check_date(digits_next);

        pos_next = pos_after;
        err_next = err_after;
        if (din.end_of_text)
        begin
            pos_next = 4'd0;
            err_next = 1'b0;
        end
    end

    assign push            = accept && din.end_of_text;
    assign push_rec.ok     = date_good;
    assign push_rec.digits = digits_next;

    // Hold the parse state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= 4'd0;
            err_reg <= 1'b0;
        end
        else if (accept)
        begin
            pos_reg <= pos_next;
            err_reg <= err_next;
        end
    end

    // Digit store needs no reset
    always_ff @(posedge clk)
    begin
        if (accept)
            digits_reg <= digits_next;
    end

endmodule

[design/dvr_queue.sv]
// ----------------------------------------------------------------------------
// dvr_queue
// Small first-in first-out buffer of classified date records.
// ----------------------------------------------------------------------------
module dvr_queue #(
    parameter int DEPTH = 2
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  dvr_pkg::dvr_rec_t push_rec,
    input  logic              pop,
    output logic              full,
    output logic              empty,
    output dvr_pkg::dvr_rec_t head_rec
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    dvr_pkg::dvr_rec_t mem_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              do_push;
    logic              do_pop;

    assign full     = (count_reg == CNT_W'(DEPTH));
    assign empty    = (count_reg == '0);
    assign head_rec = mem_reg[rd_ptr_reg];
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;

    // Advance pointers with wrap and track the fill level
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        if (do_push && !do_pop)
            count_next = count_reg + CNT_W'(1);
        else if (do_pop && !do_push)
            count_next = count_reg - CNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Write the entry storage
    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= push_rec;
    end

endmodule

[design/dvr_back.sv]
// ----------------------------------------------------------------------------
// dvr_back
// Takes records from the queue and emits dd-mm-yyyy one character per item
// through an output register, or one error item for a rejected date.
// ----------------------------------------------------------------------------
module dvr_back (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              empty,
    input  dvr_pkg::dvr_rec_t head_rec,
    output logic              pop,
    dvr_out_if.source         dout
);

    logic [3:0] idx_reg, idx_next;
    logic       valid_reg, valid_next;
    logic [7:0] char_reg, char_next;
    logic       ok_reg, ok_next;
    logic       last_reg, last_next;
    logic       load;
    logic [3:0] digit;
    logic       is_sep;

    assign load = !empty && (!valid_reg || dout.ready);

    // Pick the digit for the current output position
    always_comb
    begin
        is_sep = 1'b0;
        digit  = 4'd0;
        case (idx_reg)
            4'd0:       digit  = head_rec.digits[6];
            4'd1:       digit  = head_rec.digits[7];
            4'd2:       is_sep = 1'b1;
            4'd3:       digit  = head_rec.digits[4];
            4'd4:       digit  = head_rec.digits[5];
            4'd5:       is_sep = 1'b1;
            4'd6:       digit  = head_rec.digits[0];
            4'd7:       digit  = head_rec.digits[1];
            4'd8:       digit  = head_rec.digits[2];
            4'd9:       digit  = head_rec.digits[3];
            default:    is_sep = 1'b1;
        endcase
    end

    // Load the output register and step through the record
    always_comb
    begin
        valid_next = valid_reg;
        char_next  = char_reg;
        ok_next    = ok_reg;
        last_next  = last_reg;
        idx_next   = idx_reg;
        pop        = 1'b0;
        if (load)
        begin
            valid_next = 1'b1;
            if (head_rec.ok)
            begin
                char_next = is_sep ? dvr_pkg::ASCII_DASH : dvr_pkg::ASCII_ZERO + {4'd0, digit};
                ok_next   = 1'b1;
                last_next = (idx_reg == dvr_pkg::OUT_LEN - 4'd1);
                if (last_next)
                begin
                    idx_next = 4'd0;
                    pop      = 1'b1;
                end
                else
                    idx_next = idx_reg + 4'd1;
            end
            else
            begin
                char_next = 8'd0;
                ok_next   = 1'b0;
                last_next = 1'b1;
                idx_next  = 4'd0;
                pop       = 1'b1;
            end
        end
        else if (dout.ready)
            valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            idx_reg   <= 4'd0;
        end
        else
        begin
            valid_reg <= valid_next;
            idx_reg   <= idx_next;
        end
    end

    // Payload of the output register
    always_ff @(posedge clk)
    begin
        char_reg <= char_next;
        ok_reg   <= ok_next;
        last_reg <= last_next;
    end

    assign dout.valid      = valid_reg;
    assign dout.out_char   = char_reg;
    assign dout.date_ok    = ok_reg;
    assign dout.final_char = last_reg;

endmodule

[test/dvr_date_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dvr_date_checker
// Watches both channels of the date reorder block, predicts the result items
// of every accepted text and compares each result item, field by field, with
// the oldest prediction. Reports the failure count and what is still awaited.
// ----------------------------------------------------------------------------
module dvr_date_checker (
    input  logic clk,
    input  logic rst_n,
    dvr_in_if    din,
    dvr_out_if   dout,
    output int   fails,
    output int   pending,
    output int   dates_valid,
    output int   dates_rejected,
    output int   results_checked
);

    typedef struct packed {
        logic [7:0] ch;
        logic       ok;
        logic       fin;
    } date_char_t;

    // Predictor state: position in the text, stored digits y y y y m m d d, error flag
    logic [3:0] text_pos;
    logic [3:0] digit_buf [8];
    logic       bad_format;

    date_char_t reordered_q [$];

    // True when the stored digits form a real Gregorian calendar date
    function automatic logic calendar_ok(input logic [3:0] dg [8]);
        int year;
        int month;
        int day;
        int month_len;
        logic leap;
        year  = dg[0] * 1000 + dg[1] * 100 + dg[2] * 10 + dg[3];
        month = dg[4] * 10 + dg[5];
        day   = dg[6] * 10 + dg[7];
        if (year == 0 || month == 0 || month > 12)
            return 1'b0;
        leap = (year % 4 == 0) && ((year % 100 != 0) || (year % 400 == 0));
        case (month)
            2:             month_len = leap ? 29 : 28;
            4, 6, 9, 11:   month_len = 30;
            default:       month_len = 31;
        endcase
        return (day != 0) && (day <= month_len);
    endfunction

    // Build one valid result item from a stored digit
    function automatic date_char_t digit_item(input logic [3:0] v, input logic fin);
        date_char_t r;
        r = '{dvr_pkg::ASCII_ZERO + 8'(v), 1'b1, fin};
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        logic [7:0] c;
        logic [3:0] slot;
        logic       valid_date;
        date_char_t got;
        date_char_t want;
        if (!rst_n)
        begin
            text_pos         = '0;
            bad_format       = 1'b0;
            fails           <= 0;
            pending         <= 0;
            dates_valid     <= 0;
            dates_rejected  <= 0;
            results_checked <= 0;
            for (int k = 0; k < 8; k++)
                digit_buf[k] = '0;
            reordered_q.delete();
        end
        else
        begin
            // Advance the predictor on each accepted character
            if (din.valid && din.ready)
            begin
                c = din.in_char;
                if (text_pos >= dvr_pkg::DATE_LEN)
                    bad_format = 1'b1;
                else if (text_pos == dvr_pkg::SEP_POS_A || text_pos == dvr_pkg::SEP_POS_B)
                begin
                    if (c != dvr_pkg::ASCII_DASH)
                        bad_format = 1'b1;
                end
                else if (!(c inside {[dvr_pkg::ASCII_ZERO : dvr_pkg::ASCII_NINE]}))
                    bad_format = 1'b1;
                else
                begin
                    slot = (text_pos < dvr_pkg::SEP_POS_A) ? text_pos :
                           (text_pos < dvr_pkg::SEP_POS_B) ? text_pos - 4'd1 :
                           text_pos - 4'd2;
                    digit_buf[slot[2:0]] = 4'(c - dvr_pkg::ASCII_ZERO);
                end
                if (text_pos < dvr_pkg::DATE_LEN)
                    text_pos = text_pos + 4'd1;

                // Queue the reordered text or a single error item at the end of a text
                if (din.end_of_text)
                begin
                    valid_date = !bad_format && text_pos == dvr_pkg::DATE_LEN
                                 && calendar_ok(digit_buf);
                    if (valid_date)
                    begin
                        reordered_q.push_back(digit_item(digit_buf[6], 1'b0));
                        reordered_q.push_back(digit_item(digit_buf[7], 1'b0));
                        reordered_q.push_back('{dvr_pkg::ASCII_DASH, 1'b1, 1'b0});
                        reordered_q.push_back(digit_item(digit_buf[4], 1'b0));
                        reordered_q.push_back(digit_item(digit_buf[5], 1'b0));
                        reordered_q.push_back('{dvr_pkg::ASCII_DASH, 1'b1, 1'b0});
                        reordered_q.push_back(digit_item(digit_buf[0], 1'b0));
                        reordered_q.push_back(digit_item(digit_buf[1], 1'b0));
                        reordered_q.push_back(digit_item(digit_buf[2], 1'b0));
                        reordered_q.push_back(digit_item(digit_buf[3], 1'b1));
                        dates_valid <= dates_valid + 1;
                    end
                    else
                    begin
                        reordered_q.push_back('{8'h00, 1'b0, 1'b1});
                        dates_rejected <= dates_rejected + 1;
                    end
                    text_pos   = '0;
                    bad_format = 1'b0;
                end
            end

            // Compare each accepted result item with the oldest prediction
            if (dout.valid && dout.ready)
            begin
                got = '{dout.out_char, dout.date_ok, dout.final_char};
                if (reordered_q.size() == 0)
                begin
                    if (fails < 10)
                        $display("%0t: unexpected result item char=%h ok=%b final=%b",
                                 $realtime, got.ch, got.ok, got.fin);
                    fails <= fails + 1;
                end
                else
                begin
                    want = reordered_q.pop_front();
                    if (got !== want)
                    begin
                        if (fails < 10)
                            $display("%0t: mismatch exp %h/%b/%b got %h/%b/%b",
                                     $realtime, want.ch, want.ok, want.fin,
                                     got.ch, got.ok, got.fin);
                        fails <= fails + 1;
                    end
                end
                results_checked <= results_checked + 1;
            end
            pending <= reordered_q.size();
        end
    end

endmodule

[test/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Drives date texts into the date reorder block: a few directed dates and
// single bytes, then random well-formed and broken texts, with random idling
// on both channels. The checker beside the block does the prediction.
// ----------------------------------------------------------------------------
module tb;

    localparam int TARGET_ITEMS = 380;
    localparam int CALM_ITEMS   = 320;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 20;

    logic       clk;
    logic       rst_n      = 1'b0;
    logic       send_valid = 1'b0;
    logic [7:0] send_byte  = '0;
    logic       send_last  = 1'b0;
    logic       take_ready = 1'b0;

    logic quiet = 1'b0;
    logic calm  = 1'b0;
    int   stall_left = 0;
    int   items_sent = 0;
    int   cycles = 0;

    int fails;
    int pending;
    int dates_valid;
    int dates_rejected;
    int results_checked;

    logic [7:0] txt [$];

    dvr_in_if  din ();
    dvr_out_if dout ();

    assign din.valid       = send_valid;
    assign din.in_char     = send_byte;
    assign din.end_of_text = send_last;
    assign dout.ready      = take_ready;

    iso_date_validate_reorder_core i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .din   (din),
        .dout  (dout)
    );

    dvr_date_checker i_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .din             (din),
        .dout            (dout),
        .fails           (fails),
        .pending         (pending),
        .dates_valid     (dates_valid),
        .dates_rejected  (dates_rejected),
        .results_checked (results_checked)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Stop a hung run
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles, %0d results still awaited", cycles, pending);
            $display("Regression FAIL");
            $finish;
        end
    end

    // Stall the result channel in random bursts
    always @(posedge clk)
    begin
        if (!rst_n)
            take_ready <= 1'b0;
        else if (calm || quiet)
            take_ready <= 1'b1;
        else if (stall_left > 0)
        begin
            take_ready <= 1'b0;
            stall_left <= stall_left - 1;
        end
        else if ($urandom_range(0, 5) == 0)
        begin
            take_ready <= 1'b0;
            stall_left <= $urandom_range(1, 8) - 1;
        end
        else
            take_ready <= 1'b1;
    end

    // Push the digits of a yyyy-mm-dd text
    task automatic make_date(input int y, input int m, input int d);
        txt.push_back(dvr_pkg::ASCII_ZERO + 8'(y / 1000 % 10));
        txt.push_back(dvr_pkg::ASCII_ZERO + 8'(y / 100 % 10));
        txt.push_back(dvr_pkg::ASCII_ZERO + 8'(y / 10 % 10));
        txt.push_back(dvr_pkg::ASCII_ZERO + 8'(y % 10));
        txt.push_back(dvr_pkg::ASCII_DASH);
        txt.push_back(dvr_pkg::ASCII_ZERO + 8'(m / 10 % 10));
        txt.push_back(dvr_pkg::ASCII_ZERO + 8'(m % 10));
        txt.push_back(dvr_pkg::ASCII_DASH);
        txt.push_back(dvr_pkg::ASCII_ZERO + 8'(d / 10 % 10));
        txt.push_back(dvr_pkg::ASCII_ZERO + 8'(d % 10));
    endtask

    // Send the text one item per character, end flag on the last one
    task automatic send_text();
        int gap;
        for (int k = 0; k < txt.size(); k++)
        begin
            if (!calm && !quiet && $urandom_range(0, 3) == 0)
            begin
                gap = $urandom_range(1, 8);
                send_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            send_valid <= 1'b1;
            send_byte  <= txt[k];
            send_last  <= (k == txt.size() - 1);
            @(posedge clk);
            while (!din.ready)
                @(posedge clk);
            items_sent++;
        end
        txt.delete();
    endtask

    initial
    begin
        int y;
        int m;
        int d;
        int kind;
        int n;
        int p;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: leap day, top of every field, extreme single-byte texts
        make_date(2024, 2, 29);
        send_text();
        make_date(9999, 12, 31);
        send_text();
        txt.push_back(8'hFF);
        send_text();
        txt.push_back(8'h00);
        send_text();

        // Random texts: mostly well-formed dates near the calendar edges, some broken
        while (items_sent < TARGET_ITEMS)
        begin
            calm = (items_sent >= CALM_ITEMS);
            if ($urandom_range(0, 7) == 0)
                quiet = ~quiet;

            case ($urandom_range(0, 5))
                0:       y = 0;
                1:       y = 4 * $urandom_range(0, 2499);
                2:       y = 100 * $urandom_range(0, 99);
                3:       y = 400 * $urandom_range(0, 24);
                default: y = $urandom_range(1, 9999);
            endcase
            m = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 99) : $urandom_range(1, 12);
            case ($urandom_range(0, 9))
                0:          d = $urandom_range(0, 99);
                1, 2, 3:    d = $urandom_range(28, 32);
                default:    d = $urandom_range(1, 31);
            endcase
            make_date(y, m, d);

            kind = $urandom_range(0, 19);
            case (kind)
                // Corrupt one position with a random byte
                14: txt[$urandom_range(0, 9)] = 8'($urandom_range(0, 255));
                // Cut the text short
                15:
                begin
                    n = $urandom_range(1, 9);
                    while (txt.size() > n)
                        void'(txt.pop_back());
                end
                // Overrun the length
                16:
                begin
                    n = $urandom_range(1, 6);
                    repeat (n) txt.push_back(8'($urandom_range(0, 255)));
                end
                // Pure noise of random length
                17:
                begin
                    txt.delete();
                    n = $urandom_range(1, 14);
                    repeat (n) txt.push_back(8'($urandom_range(0, 255)));
                end
                // Swap a separator for a near neighbor
                18: txt[($urandom_range(0, 1) == 0) ? 4 : 7] = ($urandom_range(0, 1) == 0) ?
                                                                8'h2F : 8'h2E;
                // Replace a digit with a character just outside the digit range
                19:
                begin
                    p = $urandom_range(0, 9);
                    if (p inside {4, 7})
                        p = p + 1;
                    txt[p] = ($urandom_range(0, 1) == 0) ? 8'h2F : 8'h3A;
                end
                default: ;
            endcase
            send_text();
        end
        send_valid <= 1'b0;
        send_last  <= 1'b0;

        // Drain, then give the block time to show any stray item
        repeat (2) @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d characters in %0d texts: %0d valid dates, %0d rejected.",
                 items_sent, dates_valid + dates_rejected, dates_valid, dates_rejected);
        $display("Checked %0d result items, %0d failures, %0d still awaited.",
                 results_checked, fails, pending);
        if (fails == 0 && pending == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
